>>> rtl/dqo_pkg.sv
// dqo_pkg: shared types and constants of the dual quadrature odometer
// used by odo lanes, the merge stage and the top level; no dependencies
`default_nettype none

package dqo_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT_MAX   = 2'd0,
    CFG_SWAP_LEFT   = 2'd1,
    CFG_SWAP_RIGHT  = 2'd2,
    CFG_MM_PER_CNT  = 2'd3
  } cfg_idx_e;

  // reset values of the registers
  localparam logic [15:0] CountMaxRst = 16'd359;
  localparam logic        SwapLeftRst  = 1'b1;
  localparam logic        SwapRightRst = 1'b0;
  localparam logic [23:0] MmPerCntRst  = 24'd40034;

  // datapath widths
  localparam int unsigned CountW = 16;
  localparam int unsigned AngleW = 32;
  localparam int unsigned DistW  = 48;
  localparam int unsigned ProdW  = 57;   // 32 bit signed angle times 25 bit signed gain

  localparam logic [DistW-1:0] DistMax = {1'b0, {(DistW-1){1'b1}}};
  localparam logic [DistW-1:0] DistMin = {1'b1, {(DistW-1){1'b0}}};

  // pipeline control shared by both lanes
  typedef struct packed {
    logic take;    // input beat accepted this cycle
    logic adv;     // whole pipeline advances this cycle
    logic clear;   // accepted beat clears counts and revolutions
  } pipe_ctrl_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic [CountW-1:0]       count;
    logic [CountW-1:0]       revs;
    logic                    dir;
    logic [AngleW-1:0]       angle;
    logic signed [ProdW-1:0] prod;
  } lane_res_t;

endpackage

`default_nettype wire

>>> rtl/odo_lane.sv
// odo_lane: one wheel's x4 quadrature decoder, position and revolution
// state, and angle / distance product stages; depends on dqo_pkg
`default_nettype none

module odo_lane
  import dqo_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire pipe_ctrl_t  ctrl_i,
  input  wire              phase_a_i,
  input  wire              phase_b_i,
  input  wire              swap_i,
  input  wire [15:0]       count_max_i,
  input  wire [23:0]       mm_per_count_i,
  output lane_res_t        res_o
);

  logic [1:0]        prev_q;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] revs_q, revs_d;
  logic              dir_q, dir_d;
  logic [1:0]        cur;
  logic [1:0]        diff;
  logic              fwd;
  logic [CountW-1:0] pos_b, revs_b;

  // decode one sample against the previous one
  always_comb begin
    cur    = swap_i ? {phase_b_i, phase_a_i} : {phase_a_i, phase_b_i};
    diff   = cur ^ prev_q;
    fwd    = cur[1] ^ prev_q[0];
    pos_b  = ctrl_i.clear ? '0 : pos_q;
    revs_b = ctrl_i.clear ? '0 : revs_q;
    pos_d  = pos_b;
    revs_d = revs_b;
    dir_d  = dir_q;
    // exactly one phase changed: step one count
    if (diff[1] ^ diff[0]) begin
      dir_d = fwd;
      if (fwd) begin
        if (pos_b >= count_max_i) begin
          pos_d  = '0;
          revs_d = revs_b + 16'd1;
        end else begin
          pos_d = pos_b + 16'd1;
        end
      end else begin
        if (pos_b == '0) begin
          pos_d  = count_max_i;
          revs_d = revs_b - 16'd1;
        end else begin
          pos_d = pos_b - 16'd1;
        end
      end
    end
  end

  // wheel state, also the first pipeline stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pos_q  <= '0;
      revs_q <= '0;
      dir_q  <= 1'b0;
    end else if (ctrl_i.take) begin
      prev_q <= cur;
      pos_q  <= pos_d;
      revs_q <= revs_d;
      dir_q  <= dir_d;
    end
  end

  // stage two: angle = revs * (count_max + 1) + count
  logic [16:0]        per_rev;
  logic signed [33:0] ang_full;
  logic [CountW-1:0]  s2_pos_q, s2_revs_q;
  logic               s2_dir_q;
  logic [AngleW-1:0]  s2_angle_q;

  always_comb begin
    per_rev  = {1'b0, count_max_i} + 17'd1;
    ang_full = $signed(revs_q) * $signed({1'b0, per_rev}) + $signed({18'd0, pos_q});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      s2_pos_q   <= pos_q;
      s2_revs_q  <= revs_q;
      s2_dir_q   <= dir_q;
      s2_angle_q <= ang_full[AngleW-1:0];
    end
  end

  // stage three: angle times the millimetre gain
  logic [CountW-1:0]       s3_pos_q, s3_revs_q;
  logic                    s3_dir_q;
  logic [AngleW-1:0]       s3_angle_q;
  logic signed [ProdW-1:0] s3_prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      s3_pos_q   <= s2_pos_q;
      s3_revs_q  <= s2_revs_q;
      s3_dir_q   <= s2_dir_q;
      s3_angle_q <= s2_angle_q;
      s3_prod_q  <= $signed(s2_angle_q) * $signed({1'b0, mm_per_count_i});
    end
  end

  assign res_o.count = s3_pos_q;
  assign res_o.revs  = s3_revs_q;
  assign res_o.dir   = s3_dir_q;
  assign res_o.angle = s3_angle_q;
  assign res_o.prod  = s3_prod_q;

endmodule

`default_nettype wire

>>> rtl/odo_merge.sv
// odo_merge: saturates both lanes' distance and joins the two wheels into
// one output beat held in the output register; depends on dqo_pkg
`default_nettype none

module odo_merge
  import dqo_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               adv_i,
  input  wire               valid_i,
  input  wire lane_res_t    left_i,
  input  wire lane_res_t    right_i,
  output logic              out_valid_o,
  output logic [15:0]       left_count_o,
  output logic signed [15:0] left_revs_o,
  output logic              left_dir_o,
  output logic signed [31:0] left_angle_o,
  output logic signed [47:0] left_distance_o,
  output logic [15:0]       right_count_o,
  output logic signed [15:0] right_revs_o,
  output logic              right_dir_o,
  output logic signed [31:0] right_angle_o,
  output logic signed [47:0] right_distance_o
);

  localparam int unsigned TopW = ProdW - DistW + 1;

  logic [DistW-1:0] left_dist, right_dist;
  logic [TopW-1:0]  left_top, right_top;

  // clamp the products to the 48 bit signed range
  always_comb begin
    left_top  = left_i.prod[ProdW-1:DistW-1];
    right_top = right_i.prod[ProdW-1:DistW-1];
    if ((&left_top) || !(|left_top)) begin
      left_dist = left_i.prod[DistW-1:0];
    end else begin
      left_dist = left_top[TopW-1] ? DistMin : DistMax;
    end
    if ((&right_top) || !(|right_top)) begin
      right_dist = right_i.prod[DistW-1:0];
    end else begin
      right_dist = right_top[TopW-1] ? DistMin : DistMax;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv_i) begin
      out_valid_o <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      left_count_o     <= left_i.count;
      left_revs_o      <= left_i.revs;
      left_dir_o       <= left_i.dir;
      left_angle_o     <= left_i.angle;
      left_distance_o  <= left_dist;
      right_count_o    <= right_i.count;
      right_revs_o     <= right_i.revs;
      right_dir_o      <= right_i.dir;
      right_angle_o    <= right_i.angle;
      right_distance_o <= right_dist;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dual_quadrature_odometer_top.sv
// dual_quadrature_odometer_top: configuration registers, pipeline control,
// two odo_lane instances and the odo_merge output stage; depends on dqo_pkg
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  in       | in_valid_i / in_stall_o   | left/right phase a, b, clear
//  out      | out_valid_o / out_stall_i | left/right count, revs, dir, angle, dist
//  cfg      | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  one sample beat per cycle while the pipeline is not held; each result passes the stages below in order
//  stages: wheel state update, angle multiply-add, gain multiply, saturate + output reg
//  the whole pipeline moves as one; it holds only while a result waits under out_stall_i
//  reset clears wheel state, pipeline valids and restores register defaults
`default_nettype none

module dual_quadrature_odometer_top
  import dqo_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  // sample channel
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 left_phase_a_i,
  input  wire                 left_phase_b_i,
  input  wire                 right_phase_a_i,
  input  wire                 right_phase_b_i,
  input  wire                 clear_i,
  // result channel
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [15:0]         left_count_o,
  output logic signed [15:0]  left_revs_o,
  output logic                left_dir_o,
  output logic signed [31:0]  left_angle_o,
  output logic signed [47:0]  left_distance_o,
  output logic [15:0]         right_count_o,
  output logic signed [15:0]  right_revs_o,
  output logic                right_dir_o,
  output logic signed [31:0]  right_angle_o,
  output logic signed [47:0]  right_distance_o
);

  logic [15:0] count_max_q;
  logic        swap_left_q;
  logic        swap_right_q;
  logic [23:0] mm_per_cnt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_max_q  <= CountMaxRst;
      swap_left_q  <= SwapLeftRst;
      swap_right_q <= SwapRightRst;
      mm_per_cnt_q <= MmPerCntRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COUNT_MAX:  count_max_q  <= cfg_data_i[15:0];
        CFG_SWAP_LEFT:  swap_left_q  <= cfg_data_i[0];
        CFG_SWAP_RIGHT: swap_right_q <= cfg_data_i[0];
        CFG_MM_PER_CNT: mm_per_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control: everything advances unless a result is held
  pipe_ctrl_t ctrl;
  logic       v1_q, v2_q, v3_q;

  always_comb begin
    ctrl.adv   = !out_valid_o || !out_stall_i;
    ctrl.take  = in_valid_i && ctrl.adv;
    ctrl.clear = clear_i;
    in_stall_o = !ctrl.adv;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctrl.adv) begin
      v1_q <= ctrl.take;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // one lane per wheel
  lane_res_t left_res, right_res;

  odo_lane u_lane_left (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .phase_a_i      (left_phase_a_i),
    .phase_b_i      (left_phase_b_i),
    .swap_i         (swap_left_q),
    .count_max_i    (count_max_q),
    .mm_per_count_i (mm_per_cnt_q),
    .res_o          (left_res)
  );

  odo_lane u_lane_right (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .phase_a_i      (right_phase_a_i),
    .phase_b_i      (right_phase_b_i),
    .swap_i         (swap_right_q),
    .count_max_i    (count_max_q),
    .mm_per_count_i (mm_per_cnt_q),
    .res_o          (right_res)
  );

  // join both wheels into the output beat
  odo_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (ctrl.adv),
    .valid_i          (v3_q),
    .left_i           (left_res),
    .right_i          (right_res),
    .out_valid_o      (out_valid_o),
    .left_count_o     (left_count_o),
    .left_revs_o      (left_revs_o),
    .left_dir_o       (left_dir_o),
    .left_angle_o     (left_angle_o),
    .left_distance_o  (left_distance_o),
    .right_count_o    (right_count_o),
    .right_revs_o     (right_revs_o),
    .right_dir_o      (right_dir_o),
    .right_angle_o    (right_angle_o),
    .right_distance_o (right_distance_o)
  );

`ifndef SYNTHESIS
  // a taken sample occupies the first stage next cycle
  a_take_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.take |=> v1_q)
    else $error("accepted sample did not enter the pipeline");

  // a held pipeline keeps its last stage
  a_hold_keeps_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !ctrl.adv) |=> v3_q)
    else $error("stalled pipeline dropped a result");

  // while the output is held nothing new is taken
  a_no_take_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !ctrl.take)
    else $error("sample taken while output held");
`endif

endmodule

`default_nettype wire
